FILE: rtl/gyh_pkg.sv
// Shared types, constants and codes for the gyro yaw heading integrator.
// No dependencies; every other file imports this package.
package gyh_pkg;

    localparam int HEADING_FRAC_BITS = 16;
    localparam int BIAS_FRAC_BITS    = 8;

    localparam int RAW_W   = 16;
    localparam int TIME_W  = 32;
    localparam int HEAD_W  = 48;
    localparam int RATE_W  = 32;
    localparam int BIAS_W  = 24;
    localparam int SUM_W   = 34;
    localparam int CNT_W   = 16;
    localparam int STAT_W  = 4;
    localparam int CODE_W  = 3;
    localparam int OP_W    = 2;
    localparam int CORR_W  = RAW_W + BIAS_FRAC_BITS + 1;
    localparam int HSUM_W  = HEAD_W + 2;

    localparam int MUL_AW  = 32;
    localparam int MUL_BW  = 20;
    localparam int MUL_PW  = MUL_AW + MUL_BW;

    localparam int DIV_DW    = MUL_PW;
    localparam int DIV_SW    = 20;
    localparam int DIV_STEPS = DIV_DW / 2;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam int GYRO_LSB_DIV = 131;
    localparam int RATE_DEN     = GYRO_LSB_DIV << BIAS_FRAC_BITS;
    localparam int RATE_SHIFT   = HEADING_FRAC_BITS + 1;
    localparam int US_PER_S     = 1000000;
    localparam int PCT_SCALE    = 100;

    localparam logic [STAT_W-1:0] ST_OK          = 4'd0;
    localparam logic [STAT_W-1:0] ST_NOT_INIT    = 4'd1;
    localparam logic [STAT_W-1:0] ST_NOT_CAL     = 4'd2;
    localparam logic [STAT_W-1:0] ST_BUS_BASE    = 4'd2;
    localparam logic [STAT_W-1:0] ST_UNKNOWN     = 4'd10;
    localparam logic [STAT_W-1:0] ST_MISMATCH    = 4'd11;
    localparam logic [STAT_W-1:0] ST_CAL_FAIL    = 4'd12;
    localparam logic [STAT_W-1:0] ST_CALIBRATING = 4'd13;

    localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
    localparam logic [OP_W-1:0] OP_CALIB  = 2'd1;
    localparam logic [OP_W-1:0] OP_LOAD   = 2'd2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_READY   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CALIB_COUNT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_INTERVAL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNHEALTHY_FAIL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SUCCESS    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_DEADBAND  = 3'd5;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic                     read_ok;
        logic signed [RAW_W-1:0]  raw_rate;
        logic [TIME_W-1:0]        time_us;
        logic [CODE_W-1:0]        fail_code;
        logic                     config_intact;
        logic signed [HEAD_W-1:0] heading_load;
    } gyh_in_t;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic signed [RATE_W-1:0] yaw_rate;
        logic signed [HEAD_W-1:0] heading;
        logic [TIME_W-1:0]        interval_us;
        logic                     healthy;
        logic                     calibrated;
        logic [CNT_W-1:0]         consecutive_failures;
        logic [31:0]              total_failures;
        logic [31:0]              total_successes;
    } gyh_out_t;

    typedef struct packed {
        logic        device_ready;
        logic [15:0] calib_sample_count;
        logic [19:0] max_interval_us;
        logic [7:0]  unhealthy_fail_count;
        logic [6:0]  min_success_percent;
        logic [15:0] rate_deadband;
    } gyh_cfg_t;

    localparam gyh_cfg_t CFG_RESET = '{
        device_ready:         1'b0,
        calib_sample_count:   16'd64,
        max_interval_us:      20'd100000,
        unhealthy_fail_count: 8'd3,
        min_success_percent:  7'd80,
        rate_deadband:        16'd0
    };

    typedef struct packed {
        logic              start;
        logic [DIV_DW-1:0] dividend;
        logic [DIV_SW-1:0] divisor;
    } gyh_div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIV_DW-1:0] quotient;
    } gyh_div_rsp_t;

    typedef struct packed {
        logic [MUL_AW-1:0] a;
        logic [MUL_BW-1:0] b;
    } gyh_mul_req_t;

endpackage

FILE: rtl/gyh_sample_if.sv
// Input channel carrying one gyro sample or command item.
// Depends on gyh_pkg for the item type.
interface gyh_sample_if;
    import gyh_pkg::*;

    logic    valid;
    logic    ready;
    gyh_in_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/gyh_result_if.sv
// Output channel carrying one result item.
// Depends on gyh_pkg for the item type.
interface gyh_result_if;
    import gyh_pkg::*;

    logic     valid;
    logic     ready;
    gyh_out_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/gyro_yaw_heading_integrator.sv
// Top level of the gyro yaw heading integrator: configuration registers,
// channel hookup, sequencer core, shared divider and multiplier.
// Depends on gyh_pkg, gyh_sample_if, gyh_result_if, gyh_core, gyh_div, gyh_mul.
//
// Channel | Direction | Payload                    | Transfer
// sample  | in        | gyh_in_t item              | valid && ready
// result  | out       | gyh_out_t item             | valid && ready
// cfg     | in        | cfg_index, cfg_wdata[19:0] | cfg_we
//
// Commands and rejected or failed samples go from evaluation straight to result.
// A good sample waits on the rate divide, and on a multiply and heading divide
// when integrated; each division runs on the shared two-bit-per-cycle divider.
// The last calibration sample adds a percent check and a bias divide.
// Reset is asynchronous: control state clears, configuration returns to defaults.
// One result register holds a finished item; a new item is accepted while it
// waits, and the sequencer holds in its last step until the register frees.
module gyro_yaw_heading_integrator (
    input  logic                               clk,
    input  logic                               rst_n,
    gyh_sample_if.sink                         sample,
    gyh_result_if.source                       result,
    input  logic                               cfg_we,
    input  logic [gyh_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gyh_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import gyh_pkg::*;

    gyh_cfg_t          cfg_reg, cfg_next;
    gyh_div_req_t      div_req;
    gyh_div_rsp_t      div_rsp;
    gyh_mul_req_t      mul_req;
    logic [MUL_PW-1:0] mul_prod;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DEVICE_READY:   cfg_next.device_ready         = cfg_wdata[0];
                CFG_CALIB_COUNT:    cfg_next.calib_sample_count   = cfg_wdata[15:0];
                CFG_MAX_INTERVAL:   cfg_next.max_interval_us      = cfg_wdata[19:0];
                CFG_UNHEALTHY_FAIL: cfg_next.unhealthy_fail_count = cfg_wdata[7:0];
                CFG_MIN_SUCCESS:    cfg_next.min_success_percent  = cfg_wdata[6:0];
                CFG_RATE_DEADBAND:  cfg_next.rate_deadband        = cfg_wdata[15:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    gyh_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (sample.valid),
        .in_data   (sample.data),
        .in_ready  (sample.ready),
        .out_valid (result.valid),
        .out_data  (result.data),
        .out_ready (result.ready),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .mul_req   (mul_req),
        .mul_prod  (mul_prod)
    );

    gyh_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    gyh_mul u_mul (
        .clk  (clk),
        .req  (mul_req),
        .prod (mul_prod)
    );

endmodule

FILE: rtl/gyh_div.sv
// Shared unsigned restoring divider, two quotient bits per cycle.
// Depends on gyh_pkg; done pulses one cycle with the quotient.
module gyh_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  gyh_pkg::gyh_div_req_t req,
    output gyh_pkg::gyh_div_rsp_t rsp
);
    import gyh_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_SW-1:0]    rem_reg, rem_next;
    logic [DIV_SW-1:0]    dsr_reg, dsr_next;
    logic [DIV_DW-1:0]    quo_reg, quo_next;
    logic [DIV_SW:0]      step1, step2;

    function automatic logic [DIV_SW:0] div_step(input logic [DIV_SW-1:0] rem,
                                                  input logic bit_in,
                                                  input logic [DIV_SW-1:0] dsr);
        logic [DIV_SW:0] t;
        logic [DIV_SW:0] d;
        t = {rem, bit_in};
        d = {1'b0, dsr};
        if (t >= d)
        begin
            return {1'b1, DIV_SW'(t - d)};
        end
        return {1'b0, t[DIV_SW-1:0]};
    endfunction

    always_comb
    begin
        step1     = div_step(rem_reg, quo_reg[DIV_DW-1], dsr_reg);
        step2     = div_step(step1[DIV_SW-1:0], quo_reg[DIV_DW-2], dsr_reg);
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_STEPS - 1);
            rem_next  = '0;
            dsr_next  = req.divisor;
            quo_next  = req.dividend;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DIV_DW-3:0], step1[DIV_SW], step2[DIV_SW]};
            rem_next = step2[DIV_SW-1:0];
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

FILE: rtl/gyh_mul.sv
// Shared unsigned multiplier with a registered product.
// Depends on gyh_pkg; the product is registered, valid in the cycle after the operands.
module gyh_mul (
    input  logic                        clk,
    input  gyh_pkg::gyh_mul_req_t       req,
    output logic [gyh_pkg::MUL_PW-1:0]  prod
);
    import gyh_pkg::*;

    logic [MUL_PW-1:0] prod_reg, prod_next;

    always_comb
    begin
        prod_next = MUL_PW'(req.a) * MUL_PW'(req.b);
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

FILE: rtl/gyh_core.sv
// Sequencer, state registers and output register of the yaw integrator.
// Depends on gyh_pkg; drives the shared divider and multiplier.
module gyh_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  gyh_pkg::gyh_cfg_t           cfg,
    input  logic                        in_valid,
    input  gyh_pkg::gyh_in_t            in_data,
    output logic                        in_ready,
    output logic                        out_valid,
    output gyh_pkg::gyh_out_t           out_data,
    input  logic                        out_ready,
    output gyh_pkg::gyh_div_req_t       div_req,
    input  gyh_pkg::gyh_div_rsp_t       div_rsp,
    output gyh_pkg::gyh_mul_req_t       mul_req,
    input  logic [gyh_pkg::MUL_PW-1:0]  mul_prod
);
    import gyh_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_EVAL  = 10'b0000000010,
        S_PCT   = 10'b0000000100,
        S_JUDGE = 10'b0000001000,
        S_BIAS  = 10'b0000010000,
        S_RATE  = 10'b0000100000,
        S_HMUL  = 10'b0001000000,
        S_HDIV  = 10'b0010000000,
        S_HACC  = 10'b0100000000,
        S_EMIT  = 10'b1000000000
    } state_t;

    state_t                   state_reg, state_next;
    gyh_in_t                  item_reg, item_next;
    logic [STAT_W-1:0]        st_reg, st_next;
    logic [TIME_W-1:0]        used_reg, used_next;
    logic [TIME_W-1:0]        interval_reg, interval_next;
    logic                     integrate_reg, integrate_next;
    logic                     sign_reg, sign_next;
    logic signed [BIAS_W-1:0] bias_reg, bias_next;
    logic signed [HEAD_W-1:0] heading_reg, heading_next;
    logic signed [RATE_W-1:0] rate_reg, rate_next;
    logic [TIME_W-1:0]        last_time_reg, last_time_next;
    logic                     time_valid_reg, time_valid_next;
    logic [CNT_W-1:0]         fail_run_reg, fail_run_next;
    logic [31:0]              fail_total_reg, fail_total_next;
    logic [31:0]              success_total_reg, success_total_next;
    logic                     calib_reg, calib_next;
    logic                     healthy_reg, healthy_next;
    logic                     calibrating_reg, calibrating_next;
    logic [CNT_W-1:0]         calib_left_reg, calib_left_next;
    logic signed [SUM_W-1:0]  calib_sum_reg, calib_sum_next;
    logic [CNT_W-1:0]         calib_good_reg, calib_good_next;
    logic                     out_valid_reg, out_valid_next;
    gyh_out_t                 out_reg, out_next;

    logic                     out_load;
    logic                     fail_evt;
    logic                     recovering;
    logic [TIME_W-1:0]        interval_sel;
    logic signed [CORR_W-1:0] corr;
    logic [CORR_W-1:0]        corr_mag;
    logic [CORR_W-1:0]        rate_mag;
    logic [SUM_W-1:0]         sum_mag;
    logic [RATE_W-1:0]        rate_abs;
    logic [CNT_W-1:0]         fail_run_inc;
    logic [CNT_W-1:0]         left_dec;
    logic [CNT_W-1:0]         good_new;
    logic [MUL_PW-1:0]        pct_lhs;
    logic [TIME_W-1:0]        hq;
    logic signed [HSUM_W-1:0] hsum;

    function automatic logic [STAT_W-1:0] fail_status(input logic [CODE_W-1:0] code);
        return (code == '0) ? ST_UNKNOWN : ST_BUS_BASE + STAT_W'(code);
    endfunction

    function automatic logic [RATE_W-1:0] clamp_rate(input logic neg,
                                                      input logic [DIV_DW-1:0] q);
        logic [RATE_W-1:0] r;
        if (!neg)
        begin
            r = (q > DIV_DW'({1'b0, {(RATE_W-1){1'b1}}})) ?
                {1'b0, {(RATE_W-1){1'b1}}} : q[RATE_W-1:0];
        end
        else
        begin
            r = (q > DIV_DW'({1'b1, {(RATE_W-1){1'b0}}})) ?
                {1'b1, {(RATE_W-1){1'b0}}} : ~q[RATE_W-1:0] + 1'b1;
        end
        return r;
    endfunction

    function automatic logic [BIAS_W-1:0] clamp_bias(input logic neg,
                                                      input logic [DIV_DW-1:0] q);
        logic [BIAS_W-1:0] r;
        if (!neg)
        begin
            r = (q > DIV_DW'({1'b0, {(BIAS_W-1){1'b1}}})) ?
                {1'b0, {(BIAS_W-1){1'b1}}} : q[BIAS_W-1:0];
        end
        else
        begin
            r = (q > DIV_DW'({1'b1, {(BIAS_W-1){1'b0}}})) ?
                {1'b1, {(BIAS_W-1){1'b0}}} : ~q[BIAS_W-1:0] + 1'b1;
        end
        return r;
    endfunction

    always_comb
    begin
        recovering   = fail_run_reg != '0;
        interval_sel = (!time_valid_reg || recovering) ?
                       '0 : item_reg.time_us - last_time_reg;
        corr         = (CORR_W'(item_reg.raw_rate) <<< BIAS_FRAC_BITS) - CORR_W'(bias_reg);
        corr_mag     = corr[CORR_W-1] ? CORR_W'(-corr) : CORR_W'(corr);
        rate_mag     = (corr_mag < CORR_W'(cfg.rate_deadband)) ? '0 : corr_mag;
        sum_mag      = calib_sum_reg[SUM_W-1] ? SUM_W'(-calib_sum_reg) : SUM_W'(calib_sum_reg);
        rate_abs     = rate_reg[RATE_W-1] ? RATE_W'(-rate_reg) : RATE_W'(rate_reg);
        fail_run_inc = (fail_run_reg == '1) ? fail_run_reg : fail_run_reg + 1'b1;
        left_dec     = (calib_left_reg != '0) ? calib_left_reg - 1'b1 : '0;
        good_new     = item_reg.read_ok ? calib_good_reg + 1'b1 : calib_good_reg;
        pct_lhs      = MUL_PW'(calib_good_reg) * MUL_PW'(PCT_SCALE);
        hq           = div_rsp.quotient[TIME_W-1:0];
        hsum         = HSUM_W'(heading_reg) +
                       (sign_reg ? -$signed(HSUM_W'(hq)) : $signed(HSUM_W'(hq)));
    end

    always_comb
    begin
        state_next         = state_reg;
        item_next          = item_reg;
        st_next            = st_reg;
        used_next          = used_reg;
        interval_next      = interval_reg;
        integrate_next     = integrate_reg;
        sign_next          = sign_reg;
        bias_next          = bias_reg;
        heading_next       = heading_reg;
        rate_next          = rate_reg;
        last_time_next     = last_time_reg;
        time_valid_next    = time_valid_reg;
        fail_run_next      = fail_run_reg;
        fail_total_next    = fail_total_reg;
        success_total_next = success_total_reg;
        calib_next         = calib_reg;
        healthy_next       = healthy_reg;
        calibrating_next   = calibrating_reg;
        calib_left_next    = calib_left_reg;
        calib_sum_next     = calib_sum_reg;
        calib_good_next    = calib_good_reg;
        div_req            = '0;
        mul_req            = '0;
        out_load           = 1'b0;
        fail_evt           = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next  = in_data;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                used_next  = '0;
                state_next = S_EMIT;
                case (item_reg.op)
                    OP_SAMPLE:
                    begin
                        if (calibrating_reg)
                        begin
                            if (item_reg.read_ok)
                            begin
                                calib_sum_next     = calib_sum_reg + SUM_W'(item_reg.raw_rate);
                                calib_good_next    = good_new;
                                success_total_next = success_total_reg + 1'b1;
                                fail_run_next      = '0;
                                st_next            = ST_CALIBRATING;
                            end
                            else
                            begin
                                fail_evt = 1'b1;
                                st_next  = fail_status(item_reg.fail_code);
                            end
                            calib_left_next = left_dec;
                            if (left_dec == '0)
                            begin
                                calibrating_next = 1'b0;
                                if (good_new == '0 || cfg.calib_sample_count == '0)
                                begin
                                    st_next = ST_CAL_FAIL;
                                end
                                else
                                begin
                                    state_next = S_PCT;
                                end
                            end
                        end
                        else if (!cfg.device_ready)
                        begin
                            healthy_next = 1'b0;
                            st_next      = ST_NOT_INIT;
                        end
                        else if (!calib_reg)
                        begin
                            healthy_next = 1'b0;
                            st_next      = ST_NOT_CAL;
                        end
                        else if (recovering && !item_reg.config_intact)
                        begin
                            fail_evt = 1'b1;
                            st_next  = ST_MISMATCH;
                        end
                        else if (!item_reg.read_ok)
                        begin
                            fail_evt = 1'b1;
                            st_next  = fail_status(item_reg.fail_code);
                        end
                        else
                        begin
                            interval_next      = interval_sel;
                            integrate_next     = (interval_sel != '0) &&
                                                 (interval_sel <= TIME_W'(cfg.max_interval_us));
                            last_time_next     = item_reg.time_us;
                            time_valid_next    = 1'b1;
                            success_total_next = success_total_reg + 1'b1;
                            fail_run_next      = '0;
                            healthy_next       = 1'b1;
                            st_next            = ST_OK;
                            sign_next          = corr[CORR_W-1];
                            div_req.start      = 1'b1;
                            div_req.dividend   = (DIV_DW'(rate_mag) << RATE_SHIFT) +
                                                 DIV_DW'(RATE_DEN / 2);
                            div_req.divisor    = DIV_SW'(RATE_DEN);
                            state_next         = S_RATE;
                        end
                    end
                    OP_CALIB:
                    begin
                        calib_next       = 1'b0;
                        healthy_next     = 1'b0;
                        bias_next        = '0;
                        rate_next        = '0;
                        calibrating_next = 1'b0;
                        if (!cfg.device_ready)
                        begin
                            st_next = ST_NOT_INIT;
                        end
                        else if (cfg.calib_sample_count == '0)
                        begin
                            st_next = ST_CAL_FAIL;
                        end
                        else
                        begin
                            calibrating_next = 1'b1;
                            calib_left_next  = cfg.calib_sample_count;
                            calib_sum_next   = '0;
                            calib_good_next  = '0;
                            st_next          = ST_CALIBRATING;
                        end
                    end
                    OP_LOAD:
                    begin
                        heading_next = item_reg.heading_load;
                        st_next      = ST_OK;
                    end
                    default:
                    begin
                        st_next = ST_UNKNOWN;
                    end
                endcase
            end
            S_PCT:
            begin
                mul_req.a  = MUL_AW'(cfg.calib_sample_count);
                mul_req.b  = MUL_BW'(cfg.min_success_percent);
                state_next = S_JUDGE;
            end
            S_JUDGE:
            begin
                if (pct_lhs < mul_prod)
                begin
                    st_next    = ST_CAL_FAIL;
                    state_next = S_EMIT;
                end
                else
                begin
                    sign_next        = calib_sum_reg[SUM_W-1];
                    div_req.start    = 1'b1;
                    div_req.dividend = (DIV_DW'(sum_mag) << BIAS_FRAC_BITS) +
                                       DIV_DW'(calib_good_reg >> 1);
                    div_req.divisor  = DIV_SW'(calib_good_reg);
                    state_next       = S_BIAS;
                end
            end
            S_BIAS:
            begin
                if (div_rsp.done)
                begin
                    bias_next       = $signed(clamp_bias(sign_reg, div_rsp.quotient));
                    calib_next      = 1'b1;
                    healthy_next    = 1'b1;
                    fail_run_next   = '0;
                    time_valid_next = 1'b0;
                    last_time_next  = '0;
                    heading_next    = '0;
                    st_next         = ST_OK;
                    state_next      = S_EMIT;
                end
            end
            S_RATE:
            begin
                if (div_rsp.done)
                begin
                    rate_next  = $signed(clamp_rate(sign_reg, div_rsp.quotient));
                    state_next = integrate_reg ? S_HMUL : S_EMIT;
                end
            end
            S_HMUL:
            begin
                sign_next  = rate_reg[RATE_W-1];
                mul_req.a  = rate_abs;
                mul_req.b  = MUL_BW'(interval_reg);
                state_next = S_HDIV;
            end
            S_HDIV:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = mul_prod + DIV_DW'(US_PER_S / 2);
                div_req.divisor  = DIV_SW'(US_PER_S);
                state_next       = S_HACC;
            end
            S_HACC:
            begin
                if (div_rsp.done)
                begin
                    if (hsum[HSUM_W-1:HEAD_W-1] == '0 || hsum[HSUM_W-1:HEAD_W-1] == '1)
                    begin
                        heading_next = hsum[HEAD_W-1:0];
                    end
                    else if (hsum[HSUM_W-1])
                    begin
                        heading_next = {1'b1, {(HEAD_W-1){1'b0}}};
                    end
                    else
                    begin
                        heading_next = {1'b0, {(HEAD_W-1){1'b1}}};
                    end
                    used_next  = interval_reg;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (fail_evt)
        begin
            fail_total_next = fail_total_reg + 1'b1;
            fail_run_next   = fail_run_inc;
            if (fail_run_inc >= CNT_W'(cfg.unhealthy_fail_count))
            begin
                healthy_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        out_next.status               = st_reg;
        out_next.yaw_rate             = rate_reg;
        out_next.heading              = heading_reg;
        out_next.interval_us          = used_reg;
        out_next.healthy              = healthy_reg;
        out_next.calibrated           = calib_reg;
        out_next.consecutive_failures = fail_run_reg;
        out_next.total_failures       = fail_total_reg;
        out_next.total_successes      = success_total_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            out_valid_reg     <= 1'b0;
            bias_reg          <= '0;
            heading_reg       <= '0;
            rate_reg          <= '0;
            last_time_reg     <= '0;
            time_valid_reg    <= 1'b0;
            fail_run_reg      <= '0;
            fail_total_reg    <= '0;
            success_total_reg <= '0;
            calib_reg         <= 1'b0;
            healthy_reg       <= 1'b0;
            calibrating_reg   <= 1'b0;
            calib_left_reg    <= '0;
            calib_sum_reg     <= '0;
            calib_good_reg    <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            out_valid_reg     <= out_valid_next;
            bias_reg          <= bias_next;
            heading_reg       <= heading_next;
            rate_reg          <= rate_next;
            last_time_reg     <= last_time_next;
            time_valid_reg    <= time_valid_next;
            fail_run_reg      <= fail_run_next;
            fail_total_reg    <= fail_total_next;
            success_total_reg <= success_total_next;
            calib_reg         <= calib_next;
            healthy_reg       <= healthy_next;
            calibrating_reg   <= calibrating_next;
            calib_left_reg    <= calib_left_next;
            calib_sum_reg     <= calib_sum_next;
            calib_good_reg    <= calib_good_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        st_reg        <= st_next;
        used_reg      <= used_next;
        interval_reg  <= interval_next;
        integrate_reg <= integrate_next;
        sign_reg      <= sign_next;
        if (out_load)
        begin
            out_reg <= out_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

FILE: rtl/gyh_checker.sv
// Port-level checks for the gyro yaw heading integrator, bound to the top.
// Depends on gyh_pkg and gyro_yaw_heading_integrator.
module gyh_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input gyh_pkg::gyh_out_t out_data
);
    import gyh_pkg::*;

    logic [1:0] pend_reg, pend_next;

    always_comb
    begin
        case ({in_valid && in_ready, out_valid && out_ready})
            2'b10:   pend_next = pend_reg + 1'b1;
            2'b01:   pend_next = pend_reg - 1'b1;
            default: pend_next = pend_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item accepted while another is in work");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 2'd0)
        else $error("result without an accepted item");

    a_integrated_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.interval_us != '0 |->
        out_data.status == ST_OK && out_data.healthy && out_data.calibrated &&
        out_data.consecutive_failures == '0)
        else $error("integrated interval on a result that is not a good sample");

    a_healthy_cal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.healthy |-> out_data.calibrated)
        else $error("healthy reported without calibration");

endmodule

bind gyro_yaw_heading_integrator gyh_checker u_gyh_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (result.data)
);
